/* hw/rtl/sfr_pkg.sv */
// types and constants shared by the shape fill rasterizer
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 6;
   localparam int EXTENT_W = 7;
   localparam int BYTE_W   = 8;
   localparam int CANVAS_W = 7;
   localparam int CSR_IDX_W = 4;
   // signed coordinate width: covers anchor plus largest diamond step
   localparam int COORD_W  = 11;

   localparam logic [MODE_W-1:0] MODE_RECT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UP      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DOWN    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIAMOND = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 4'd1;

   localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;
   localparam logic [BYTE_W-1:0]   DOT_CHAR     = 8'd46;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [POS_W-1:0]    x_pos;
      logic [POS_W-1:0]    y_pos;
      logic [EXTENT_W-1:0] extent_a;
      logic [EXTENT_W-1:0] extent_b;
      logic [BYTE_W-1:0]   brush;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] cell_value;
      logic              in_range;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_READ
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/sfr_store.sv */
// row-wide frame memory with per-row valid flags and byte-masked writes
`timescale 1ns / 1ps
`default_nettype none
module sfr_store #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int CLW = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sfr_pkg::store_ctl_type        ctl,
   input  wire logic [RW-1:0]                 wr_row,
   input  wire logic [MAX_WIDTH-1:0]          wr_mask,
   input  wire logic [sfr_pkg::BYTE_W-1:0]    wr_byte,
   input  wire logic [RW-1:0]                 rd_row,
   input  wire logic [CLW-1:0]                rd_col,
   output logic      [sfr_pkg::BYTE_W-1:0]    rd_byte
);

   localparam int ROW_W = MAX_WIDTH * sfr_pkg::BYTE_W;

   logic [ROW_W-1:0]      mem [MAX_HEIGHT];
   logic [MAX_HEIGHT-1:0] valid_ff, valid_in;
   logic [MAX_WIDTH-1:0]  byte_en;
   logic [ROW_W-1:0]      wr_data;
   logic [ROW_W-1:0]      rd_data_ff;
   logic                  rd_hit_ff;
   logic [CLW-1:0]        rd_col_ff;

   // a row never written since the last clear holds dots everywhere
   always_comb begin
      for (int j = 0; j < MAX_WIDTH; j++) begin
         byte_en[j] = wr_mask[j] | ~valid_ff[wr_row];
         wr_data[j*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] =
            wr_mask[j] ? wr_byte : sfr_pkg::DOT_CHAR;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         for (int j = 0; j < MAX_WIDTH; j++) begin
            if (byte_en[j]) begin
               mem[wr_row][j*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] <=
                  wr_data[j*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
            end
         end
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_row];
         rd_hit_ff  <= valid_ff[rd_row];
         rd_col_ff  <= rd_col;
      end
   end

   assign rd_byte = rd_hit_ff ? rd_data_ff[{rd_col_ff, 3'b000} +: sfr_pkg::BYTE_W]
                              : sfr_pkg::DOT_CHAR;

endmodule
`default_nettype wire

/* hw/rtl/sfr_seq.sv */
// command sequencer: decodes commands and walks shapes one row per cycle
`timescale 1ns / 1ps
`default_nettype none
module sfr_seq #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int CLW = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int CW  = sfr_pkg::COORD_W
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire sfr_pkg::req_type            req,
   output logic                             busy,
   input  wire logic signed [CW-1:0]        live_w,
   input  wire logic signed [CW-1:0]        live_h,
   output sfr_pkg::store_ctl_type           ctl,
   output logic      [RW-1:0]               wr_row,
   output logic      [MAX_WIDTH-1:0]        wr_mask,
   output logic      [sfr_pkg::BYTE_W-1:0]  wr_byte,
   output logic      [RW-1:0]               rd_row,
   output logic      [CLW-1:0]              rd_col,
   input  wire logic [sfr_pkg::BYTE_W-1:0]  rd_byte,
   output logic                             rsp_strobe,
   output sfr_pkg::rsp_type                 rsp
);

   localparam logic signed [CW-1:0] ONE_S = CW'(1);

   sfr_pkg::state_type            state_ff, state_in;
   logic [sfr_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [sfr_pkg::POS_W-1:0]     x_ff, x_in;
   logic [sfr_pkg::POS_W-1:0]     y_ff, y_in;
   logic [sfr_pkg::EXTENT_W-1:0]  ea_ff, ea_in;
   logic [sfr_pkg::BYTE_W-1:0]    brush_ff, brush_in;
   logic [sfr_pkg::EXTENT_W:0]    step_ff, step_in;
   logic [sfr_pkg::EXTENT_W:0]    last_ff, last_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   sfr_pkg::rsp_type              rsp_ff, rsp_in;

   logic [sfr_pkg::EXTENT_W:0]    count;
   logic signed [CW-1:0]          req_x_s, req_y_s;
   logic signed [CW-1:0]          x_s, y_s, ea_s, step_s, half_s;
   logic signed [CW-1:0]          row_s, lo_s, hi_s, lo_c, hi_c, lw_m1, col_s;
   logic                          row_ok, span_ok;

   // rows to walk for the shape on the request
   always_comb begin
      case (req.mode)
         sfr_pkg::MODE_RECT:    count = {1'b0, req.extent_b};
         sfr_pkg::MODE_DIAMOND: count = {req.extent_a, 1'b1};
         default:               count = {1'b0, req.extent_a};
      endcase
   end

   // span of the current row, clipped to the canvas
   always_comb begin
      req_x_s = CW'(req.x_pos);
      req_y_s = CW'(req.y_pos);
      x_s     = CW'(x_ff);
      y_s     = CW'(y_ff);
      ea_s    = CW'(ea_ff);
      step_s  = CW'(step_ff);
      if (mode_ff == sfr_pkg::MODE_DIAMOND && step_s > ea_s) begin
         half_s = ea_s + ea_s - step_s;
      end else begin
         half_s = step_s;
      end
      if (mode_ff == sfr_pkg::MODE_DOWN) begin
         row_s = y_s - step_s;
      end else begin
         row_s = y_s + step_s;
      end
      if (mode_ff == sfr_pkg::MODE_RECT) begin
         lo_s = x_s;
         hi_s = x_s + ea_s - ONE_S;
      end else begin
         lo_s = x_s - half_s;
         hi_s = x_s + half_s;
      end
      lw_m1   = live_w - ONE_S;
      lo_c    = lo_s[CW-1] ? '0 : lo_s;
      hi_c    = (hi_s > lw_m1) ? lw_m1 : hi_s;
      row_ok  = !row_s[CW-1] && (row_s < live_h);
      span_ok = lo_c <= hi_c;
      col_s   = '0;
      for (int j = 0; j < MAX_WIDTH; j++) begin
         col_s      = CW'(j);
         wr_mask[j] = (col_s >= lo_c) && (col_s <= hi_c);
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ea_in         = ea_ff;
      brush_in      = brush_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      ctl           = '0;
      case (state_ff)
         sfr_pkg::ST_IDLE: begin
            if (start) begin
               mode_in  = req.mode;
               x_in     = req.x_pos;
               y_in     = req.y_pos;
               ea_in    = req.extent_a;
               brush_in = req.brush;
               step_in  = '0;
               last_in  = count - 1'b1;
               case (req.mode) inside
                  [sfr_pkg::MODE_RECT:sfr_pkg::MODE_DIAMOND]: begin
                     if (count == '0) begin
                        rsp_strobe_in   = 1'b1;
                        rsp_in.in_range = 1'b1;
                     end else begin
                        state_in = sfr_pkg::ST_DRAW;
                     end
                  end
                  sfr_pkg::MODE_CLEAR: begin
                     ctl.clear       = 1'b1;
                     rsp_strobe_in   = 1'b1;
                     rsp_in.in_range = 1'b1;
                  end
                  sfr_pkg::MODE_READ: begin
                     if (req_x_s < live_w && req_y_s < live_h) begin
                        ctl.rd_en = 1'b1;
                        state_in  = sfr_pkg::ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         sfr_pkg::ST_DRAW: begin
            ctl.wr_en = row_ok && span_ok;
            step_in   = step_ff + 1'b1;
            if (step_ff == last_ff) begin
               state_in        = sfr_pkg::ST_IDLE;
               rsp_strobe_in   = 1'b1;
               rsp_in.in_range = 1'b1;
            end
         end
         sfr_pkg::ST_READ: begin
            state_in          = sfr_pkg::ST_IDLE;
            rsp_strobe_in     = 1'b1;
            rsp_in.cell_value = rd_byte;
            rsp_in.in_range   = 1'b1;
         end
         default: begin
            state_in = sfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfr_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      ea_ff    <= ea_in;
      brush_ff <= brush_in;
      step_ff  <= step_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = state_ff != sfr_pkg::ST_IDLE;
   assign wr_row     = row_s[RW-1:0];
   assign wr_byte    = brush_ff;
   assign rd_row     = req_y_s[RW-1:0];
   assign rd_col     = req_x_s[CLW-1:0];
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(start) && $past(state_ff) == sfr_pkg::ST_IDLE)
                        || $past(state_ff) != sfr_pkg::ST_IDLE)
      else $error("result strobe without a command");

   a_write_only_drawing: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> state_ff == sfr_pkg::ST_DRAW)
      else $error("store write outside shape walk");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfr_pkg::ST_DRAW |-> step_ff <= last_ff)
      else $error("row step ran past last row");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfr_pkg::ST_READ |=> state_ff == sfr_pkg::ST_IDLE && rsp_strobe_ff)
      else $error("read did not complete in one cycle");

endmodule
`default_nettype wire

/* hw/rtl/shape_fill_rasterizer.sv */
// Filled shape rasterizer over a row-wide character framebuffer.
// A command is taken when start is high and busy is low; its single result
// appears on rsp_data for one cycle with rsp_strobe and cannot be held off.
// Shape fills walk the shape one row per cycle, writing a byte-masked row into
// the frame memory: extent_b rows for a rectangle, extent_a for a triangle and
// 2*extent_a+1 for a diamond, with the result in the cycle after the last row.
// A read registers the addressed row out of the frame memory, then returns the
// selected byte. Clear and canvas writes only reset the per-row valid flags:
// unwritten rows read as dots, so there is no clearing pass after reset.
// csr_ready is always high; canvas writes must only happen while idle.
`timescale 1ns / 1ps
`default_nettype none
module shape_fill_rasterizer #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire sfr_pkg::req_type                req_data,
   output logic                                 busy,
   output logic                                 rsp_strobe,
   output sfr_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sfr_pkg::CANVAS_W-1:0]    csr_data
);

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CW  = sfr_pkg::COORD_W;
   localparam logic signed [CW-1:0] MAX_W_S = CW'(MAX_WIDTH);
   localparam logic signed [CW-1:0] MAX_H_S = CW'(MAX_HEIGHT);

   logic [sfr_pkg::CANVAS_W-1:0] canvas_w_ff, canvas_w_in;
   logic [sfr_pkg::CANVAS_W-1:0] canvas_h_ff, canvas_h_in;
   logic                         csr_clear;
   logic signed [CW-1:0]         cw_s, ch_s, live_w, live_h;

   sfr_pkg::store_ctl_type       seq_ctl, store_ctl;
   logic [RW-1:0]                wr_row, rd_row;
   logic [MAX_WIDTH-1:0]         wr_mask;
   logic [sfr_pkg::BYTE_W-1:0]   wr_byte, rd_byte;
   logic [CLW-1:0]               rd_col;

   assign csr_ready = 1'b1;

   always_comb begin
      canvas_w_in = canvas_w_ff;
      canvas_h_in = canvas_h_ff;
      csr_clear   = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sfr_pkg::CSR_CANVAS_WIDTH: begin
               canvas_w_in = csr_data;
               csr_clear   = 1'b1;
            end
            sfr_pkg::CSR_CANVAS_HEIGHT: begin
               canvas_h_in = csr_data;
               csr_clear   = 1'b1;
            end
            default: begin
               csr_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_w_ff <= sfr_pkg::CANVAS_RESET;
         canvas_h_ff <= sfr_pkg::CANVAS_RESET;
      end else begin
         canvas_w_ff <= canvas_w_in;
         canvas_h_ff <= canvas_h_in;
      end
   end

   // oversized canvas registers act as the store size
   always_comb begin
      cw_s   = CW'(canvas_w_ff);
      ch_s   = CW'(canvas_h_ff);
      live_w = (cw_s > MAX_W_S) ? MAX_W_S : cw_s;
      live_h = (ch_s > MAX_H_S) ? MAX_H_S : ch_s;
   end

   always_comb begin
      store_ctl       = seq_ctl;
      store_ctl.clear = seq_ctl.clear | csr_clear;
   end

   sfr_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .busy       (busy),
      .live_w     (live_w),
      .live_h     (live_h),
      .ctl        (seq_ctl),
      .wr_row     (wr_row),
      .wr_mask    (wr_mask),
      .wr_byte    (wr_byte),
      .rd_row     (rd_row),
      .rd_col     (rd_col),
      .rd_byte    (rd_byte),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

   sfr_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .wr_row     (wr_row),
      .wr_mask    (wr_mask),
      .wr_byte    (wr_byte),
      .rd_row     (rd_row),
      .rd_col     (rd_col),
      .rd_byte    (rd_byte)
   );

endmodule
`default_nettype wire

/* test/tb_shape_fill_rasterizer.sv */
// testbench for shape_fill_rasterizer: directed and random commands checked against a frame model
`timescale 1ns / 1ps
module tb_shape_fill_rasterizer;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int IDLE_LIMIT = 3000;
   localparam int POS_BITS = sfr_pkg::POS_W;
   localparam int EXTENT_BITS = sfr_pkg::EXTENT_W;
   localparam int BYTE_BITS = sfr_pkg::BYTE_W;
   localparam int CANVAS_BITS = sfr_pkg::CANVAS_W;
   localparam logic [sfr_pkg::MODE_W-1:0] MODE_RSVD_LO = 3'd6;
   localparam logic [sfr_pkg::MODE_W-1:0] MODE_RSVD_HI = 3'd7;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   sfr_pkg::req_type req_data = '0;
   logic busy;
   logic rsp_strobe;
   sfr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sfr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sfr_pkg::CANVAS_W-1:0] csr_data = '0;

   logic [sfr_pkg::BYTE_W-1:0] shadow_frame [0:MAX_ROWS-1][0:MAX_COLS-1];
   logic [sfr_pkg::CANVAS_W-1:0] canvas_cols = sfr_pkg::CANVAS_RESET;
   logic [sfr_pkg::CANVAS_W-1:0] canvas_rows = sfr_pkg::CANVAS_RESET;
   sfr_pkg::rsp_type predicted_cells[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int gap_max = 4;
   int last_x = 0;
   int last_y = 0;

   shape_fill_rasterizer #(
      .MAX_WIDTH (MAX_COLS),
      .MAX_HEIGHT(MAX_ROWS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // frame model

   function automatic void blank_frame();
      for (int r = 0; r < MAX_ROWS; r++)
         for (int c = 0; c < MAX_COLS; c++)
            shadow_frame[r][c] = sfr_pkg::DOT_CHAR;
   endfunction

   function automatic int live_cols();
      return (int'(canvas_cols) > MAX_COLS) ? MAX_COLS : int'(canvas_cols);
   endfunction

   function automatic int live_rows();
      return (int'(canvas_rows) > MAX_ROWS) ? MAX_ROWS : int'(canvas_rows);
   endfunction

   function automatic void plot(int col, int row, logic [sfr_pkg::BYTE_W-1:0] b);
      if (col < 0 || row < 0 || col >= live_cols() || row >= live_rows())
         return;
      shadow_frame[row][col] = b;
   endfunction

   function automatic void plot_span(int cx, int row, int half,
                                     logic [sfr_pkg::BYTE_W-1:0] b);
      for (int k = -half; k <= half; k++)
         plot(cx + k, row, b);
   endfunction

   function automatic sfr_pkg::rsp_type rasterize_cmd(sfr_pkg::req_type c);
      sfr_pkg::rsp_type r;
      int x;
      int y;
      int ea;
      int eb;
      x = int'(c.x_pos);
      y = int'(c.y_pos);
      ea = int'(c.extent_a);
      eb = int'(c.extent_b);
      r.cell_value = '0;
      r.in_range = 1'b1;
      case (c.mode)
         sfr_pkg::MODE_RECT: begin
            for (int i = 0; i < eb; i++)
               for (int k = 0; k < ea; k++)
                  plot(x + k, y + i, c.brush);
         end
         sfr_pkg::MODE_UP: begin
            for (int i = 0; i < ea; i++)
               plot_span(x, y + i, i, c.brush);
         end
         sfr_pkg::MODE_DOWN: begin
            for (int i = 0; i < ea; i++)
               plot_span(x, y - i, i, c.brush);
         end
         sfr_pkg::MODE_DIAMOND: begin
            for (int i = 0; i <= ea; i++)
               plot_span(x, y + i, i, c.brush);
            for (int i = 1; i <= ea; i++)
               plot_span(x, y + ea + i, ea - i, c.brush);
         end
         sfr_pkg::MODE_CLEAR: begin
            blank_frame();
         end
         sfr_pkg::MODE_READ: begin
            if (x < live_cols() && y < live_rows())
               r.cell_value = shadow_frame[y][x];
            else
               r.in_range = 1'b0;
         end
         default: begin
            r.in_range = 1'b0;
         end
      endcase
      return r;
   endfunction

   // stimulus helpers

   function automatic sfr_pkg::req_type make_cmd(logic [sfr_pkg::MODE_W-1:0] mode,
                                                 int x, int y, int ea, int eb,
                                                 logic [sfr_pkg::BYTE_W-1:0] brush);
      sfr_pkg::req_type c;
      c.mode = mode;
      c.x_pos = POS_BITS'(x);
      c.y_pos = POS_BITS'(y);
      c.extent_a = EXTENT_BITS'(ea);
      c.extent_b = EXTENT_BITS'(eb);
      c.brush = brush;
      return c;
   endfunction

   function automatic int random_extent();
      int pick;
      pick = int'($urandom_range(0, 99));
      if (pick < 80)
         return int'($urandom_range(0, 10));
      else if (pick < 95)
         return int'($urandom_range(0, 64));
      return int'($urandom_range(0, 127));
   endfunction

   function automatic int near_coord(int anchor);
      int v;
      v = anchor + int'($urandom_range(0, 16)) - 8;
      if (v < 0)
         v = 0;
      if (v > 63)
         v = 63;
      return v;
   endfunction

   function automatic sfr_pkg::req_type random_cmd();
      sfr_pkg::req_type c;
      int pick;
      pick = int'($urandom_range(0, 99));
      c.brush = BYTE_BITS'($urandom);
      c.extent_a = EXTENT_BITS'(random_extent());
      c.extent_b = EXTENT_BITS'(random_extent());
      c.x_pos = POS_BITS'((live_cols() > 0 && $urandom_range(0, 3) != 0) ?
                $urandom_range(0, live_cols() - 1) : $urandom_range(0, 63));
      c.y_pos = POS_BITS'((live_rows() > 0 && $urandom_range(0, 3) != 0) ?
                $urandom_range(0, live_rows() - 1) : $urandom_range(0, 63));
      if (pick < 35) begin
         c.mode = sfr_pkg::MODE_READ;
         if ($urandom_range(0, 1) == 1) begin
            c.x_pos = POS_BITS'(near_coord(last_x));
            c.y_pos = POS_BITS'(near_coord(last_y));
         end
      end else if (pick < 55)
         c.mode = sfr_pkg::MODE_RECT;
      else if (pick < 68)
         c.mode = sfr_pkg::MODE_UP;
      else if (pick < 81)
         c.mode = sfr_pkg::MODE_DOWN;
      else if (pick < 93)
         c.mode = sfr_pkg::MODE_DIAMOND;
      else if (pick < 96)
         c.mode = sfr_pkg::MODE_CLEAR;
      else if (pick < 98)
         c.mode = MODE_RSVD_LO;
      else
         c.mode = MODE_RSVD_HI;
      if (c.mode <= sfr_pkg::MODE_DIAMOND) begin
         last_x = int'(c.x_pos);
         last_y = int'(c.y_pos);
      end
      return c;
   endfunction

   // drivers

   task automatic issue_cmd(input sfr_pkg::req_type c);
      int gap;
      gap = int'($urandom_range(0, gap_max));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (busy);
      predicted_cells.push_back(rasterize_cmd(c));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (predicted_cells.size() != 0 || busy);
   endtask

   task automatic set_canvas(input int cols, input int rows);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= sfr_pkg::CSR_CANVAS_WIDTH;
      csr_data <= CANVAS_BITS'(cols);
      do @(posedge clock); while (!csr_ready);
      csr_index <= sfr_pkg::CSR_CANVAS_HEIGHT;
      csr_data <= CANVAS_BITS'(rows);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      canvas_cols = CANVAS_BITS'(cols);
      canvas_rows = CANVAS_BITS'(rows);
      blank_frame();
   endtask

   task automatic flag_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // result checking

   always @(posedge clock) begin : check_rsp
      sfr_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_cells.size() == 0) begin
            flag_mismatch("result beat with no command outstanding");
         end else begin
            want = predicted_cells.pop_front();
            if (rsp_data.cell_value !== want.cell_value)
               flag_mismatch($sformatf("cell_value %0h, want %0h",
                                       rsp_data.cell_value, want.cell_value));
            if (rsp_data.in_range !== want.in_range)
               flag_mismatch($sformatf("in_range %0b, want %0b",
                                       rsp_data.in_range, want.in_range));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR at %0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // tests

   task automatic test_reset_state();
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 0, 0, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 63, 127, 127, 8'hff));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 0, 0, 0, 8'h00));
   endtask

   task automatic test_rectangles();
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 3, 3, 0, 5, 8'h41));
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 3, 3, 5, 0, 8'h41));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 3, 3, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 0, 0, 127, 127, 8'hff));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 63, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 62, 62, 64, 64, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 63, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 61, 62, 0, 0, 8'h00));
   endtask

   task automatic test_triangles();
      issue_cmd(make_cmd(sfr_pkg::MODE_CLEAR, 0, 0, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_UP, 0, 0, 64, 0, 8'h55));
      issue_cmd(make_cmd(sfr_pkg::MODE_DOWN, 63, 63, 127, 127, 8'haa));
      issue_cmd(make_cmd(sfr_pkg::MODE_UP, 20, 20, 0, 0, 8'h7e));
      issue_cmd(make_cmd(sfr_pkg::MODE_DOWN, 0, 0, 3, 0, 8'h23));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 0, 10, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 0, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 20, 20, 0, 0, 8'h00));
   endtask

   task automatic test_diamonds();
      issue_cmd(make_cmd(sfr_pkg::MODE_DIAMOND, 31, 0, 0, 0, 8'h2a));
      issue_cmd(make_cmd(sfr_pkg::MODE_DIAMOND, 31, 10, 20, 0, 8'h40));
      issue_cmd(make_cmd(sfr_pkg::MODE_DIAMOND, 0, 0, 127, 0, 8'h80));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 31, 0, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 50, 31, 0, 0, 8'h00));
   endtask

   task automatic test_clear_and_spare_modes();
      issue_cmd(make_cmd(MODE_RSVD_LO, 5, 5, 9, 9, 8'h11));
      issue_cmd(make_cmd(MODE_RSVD_HI, 63, 63, 127, 127, 8'hff));
      issue_cmd(make_cmd(sfr_pkg::MODE_CLEAR, 63, 63, 127, 127, 8'hff));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 5, 5, 0, 0, 8'h00));
   endtask

   task automatic test_canvas_registers();
      set_canvas(0, 0);
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 0, 0, 64, 64, 8'h31));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 0, 0, 0, 0, 8'h00));
      set_canvas(1, 1);
      issue_cmd(make_cmd(sfr_pkg::MODE_DIAMOND, 0, 0, 2, 0, 8'h32));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 0, 0, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 1, 0, 0, 0, 8'h00));
      set_canvas(127, 127);
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 63, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_UP, 40, 40, 30, 0, 8'h33));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 63, 63, 0, 0, 8'h00));
      set_canvas(64, 1);
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 10, 0, 4, 4, 8'h34));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 10, 1, 0, 0, 8'h00));
      set_canvas(1, 64);
      issue_cmd(make_cmd(sfr_pkg::MODE_DOWN, 0, 40, 5, 0, 8'h35));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 0, 38, 0, 0, 8'h00));
      set_canvas(37, 23);
      issue_cmd(make_cmd(sfr_pkg::MODE_RECT, 30, 20, 20, 20, 8'h36));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 36, 22, 0, 0, 8'h00));
      issue_cmd(make_cmd(sfr_pkg::MODE_READ, 37, 22, 0, 0, 8'h00));
      set_canvas(64, 64);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: ;
            1: set_canvas(int'($urandom_range(1, 8)), int'($urandom_range(1, 8)));
            2: set_canvas(127, int'($urandom_range(0, 127)));
            3: set_canvas(int'($urandom_range(1, 127)), int'($urandom_range(1, 127)));
            4: set_canvas(64, 64);
            5: set_canvas(int'($urandom_range(0, 127)), 127);
            6: set_canvas(int'($urandom_range(20, 64)), int'($urandom_range(20, 64)));
            default: set_canvas(64, 64);
         endcase
         gap_max = (phase % 3 == 1) ? 0 : 4;
         for (int n = 0; n < 200; n++) begin
            if (phase == 3 && n == 100)
               drain_results();
            issue_cmd(random_cmd());
         end
      end
   endtask

   initial begin
      blank_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_rectangles();
      test_triangles();
      test_diamonds();
      test_clear_and_spare_modes();
      test_canvas_registers();
      test_random_traffic();
      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
